@@ rtl/rdic_pkg.sv @@
// ----------------------------------------------------------------------------
// Rectangular dislocation influence coefficient: shared package
// Widths, constants, the register map and the transaction types used by
// the influence coefficient pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rdic_pkg;

  localparam int MAX_X_CELLS = 64;
  localparam int MAX_Y_CELLS = 64;

  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W   = 6;
  localparam int POS_W   = 12;
  localparam int COEF_W  = 64;

  // Geometry in hundredths of a cell. With an origin register at its top value
  // the mirror terms reach about 25400 hundredths, so magnitudes need 15 bits.
  localparam int GEO_W   = 16;
  localparam int ABS_W   = 15;
  localparam int SQ_W    = 2 * ABS_W;
  localparam int RAD_W   = SQ_W + 1;
  localparam logic signed [GEO_W-1:0] GEO_CELL = 16'sd100;
  localparam logic signed [GEO_W-1:0] GEO_HALF = 16'sd50;
  localparam logic signed [GEO_W-1:0] GEO_NEAR = 16'sd1;

  // Square root of (U^2 + V^2) * 2^32, two radicand bits a step.
  localparam int RAD_SHIFT  = 32;
  localparam int SQRT_STEPS = (RAD_W + RAD_SHIFT + 1) / 2;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int SREM_W     = ROOT_W + 2;

  // Division of root * 100 * 2^24 by |U|*|V|, one quotient bit a step.
  localparam int NUM_W     = ROOT_W + 7;
  localparam int NUM_SHIFT = 24;
  localparam int DIV_STEPS = NUM_W + NUM_SHIFT;
  localparam int QUO_W     = DIV_STEPS;
  localparam int DREM_W    = SQ_W;

  localparam int KERNEL_LAT = 3 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int N_TERMS    = 8;

  // Terms entering the sum negatively, and terms that use the lower x edge.
  localparam logic [N_TERMS-1:0] TERM_NEG    = 8'h5A;
  localparam logic [N_TERMS-1:0] TERM_LOWER  = 8'hF0;

  localparam int SCALE_W = 28;
  localparam logic [SCALE_W-1:0] SCALE_K = 28'd170891319;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_COUNT  = 2'd0,
    REG_Y_COUNT  = 2'd1,
    REG_X_ORIGIN = 2'd2,
    REG_Y_ORIGIN = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0] recv_x;
    logic [IDX_W-1:0] recv_y;
    logic [IDX_W-1:0] src_x;
    logic [IDX_W-1:0] src_y;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]         row_index;
    logic [POS_W-1:0]         col_index;
    logic signed [COEF_W-1:0] coefficient;
    logic                     index_error;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0] row_index;
    logic [POS_W-1:0] col_index;
    logic             index_error;
    logic             src_on_axis;
  } meta_t;

endpackage

`default_nettype wire

@@ rtl/rdic_kernel.sv @@
// ----------------------------------------------------------------------------
// Rectangle kernel pipeline
// Computes g(U,V) = sqrt(U^2+V^2)/(U*V) in Q.40 through a pipelined square
// root and a pipelined restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rdic_kernel (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [rdic_pkg::GEO_W-1:0] u,
  input  logic signed [rdic_pkg::GEO_W-1:0] v,
  output logic signed [rdic_pkg::COEF_W-1:0] g
);

  localparam int GEO_W  = rdic_pkg::GEO_W;
  localparam int ABS_W  = rdic_pkg::ABS_W;
  localparam int SQ_W   = rdic_pkg::SQ_W;
  localparam int RAD_W  = rdic_pkg::RAD_W;
  localparam int SQRT_STEPS = rdic_pkg::SQRT_STEPS;
  localparam int ROOT_W = rdic_pkg::ROOT_W;
  localparam int SREM_W = rdic_pkg::SREM_W;
  localparam int NUM_W  = rdic_pkg::NUM_W;
  localparam int DIV_STEPS = rdic_pkg::DIV_STEPS;
  localparam int QUO_W  = rdic_pkg::QUO_W;
  localparam int DREM_W = rdic_pkg::DREM_W;
  localparam int COEF_W = rdic_pkg::COEF_W;
  localparam int FULL_W = 2 * ROOT_W;

  logic [GEO_W-1:0] au_full;
  logic [GEO_W-1:0] av_full;
  logic [ABS_W-1:0] au_r;
  logic [ABS_W-1:0] av_r;
  logic             neg1_r;
  logic             zero1_r;

  logic [SQ_W-1:0]  squ_r;
  logic [SQ_W-1:0]  sqv_r;
  logic [SQ_W-1:0]  den2_r;
  logic             neg2_r;
  logic             zero2_r;

  logic [RAD_W-1:0]  s_rad_r  [0:SQRT_STEPS-1];
  logic [SQ_W-1:0]   s_den_r  [0:SQRT_STEPS];
  logic              s_neg_r  [0:SQRT_STEPS];
  logic              s_zero_r [0:SQRT_STEPS];
  logic [SREM_W-1:0] s_rem_r  [0:SQRT_STEPS-1];
  logic [ROOT_W-1:0] s_root_r [0:SQRT_STEPS];

  logic [NUM_W-1:0]  d_num_r  [0:NUM_W-1];
  logic [SQ_W-1:0]   d_den_r  [0:DIV_STEPS-1];
  logic [DREM_W-1:0] d_rem_r  [0:DIV_STEPS-1];
  logic [QUO_W-1:0]  d_quo_r  [0:DIV_STEPS];
  logic              d_neg_r  [0:DIV_STEPS];
  logic              d_zero_r [0:DIV_STEPS];

  logic signed [COEF_W-1:0] g_r;
  logic [COEF_W-1:0]        quo_ext;

  assign au_full = u[GEO_W-1] ? GEO_W'(-u) : GEO_W'(u);
  assign av_full = v[GEO_W-1] ? GEO_W'(-v) : GEO_W'(v);

  always_ff @(posedge clk) begin
    if (en) begin
      au_r    <= au_full[ABS_W-1:0];
      av_r    <= av_full[ABS_W-1:0];
      neg1_r  <= u[GEO_W-1] ^ v[GEO_W-1];
      zero1_r <= (u == '0) || (v == '0);

      squ_r   <= SQ_W'(au_r) * SQ_W'(au_r);
      sqv_r   <= SQ_W'(av_r) * SQ_W'(av_r);
      den2_r  <= SQ_W'(au_r) * SQ_W'(av_r);
      neg2_r  <= neg1_r;
      zero2_r <= zero1_r;

      s_rad_r[0]  <= RAD_W'(squ_r) + RAD_W'(sqv_r);
      s_den_r[0]  <= den2_r;
      s_neg_r[0]  <= neg2_r;
      s_zero_r[0] <= zero2_r;
      s_rem_r[0]  <= '0;
      s_root_r[0] <= '0;
    end
  end

  // Square root: each step brings down the next pair of radicand bits.
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [FULL_W-1:0] rfull;
    logic [1:0]        pair;
    logic [SREM_W+1:0] trial;
    logic [SREM_W+1:0] sub;
    logic [SREM_W+1:0] diff;
    logic              ge;

    assign rfull = {1'b0, s_rad_r[j], {rdic_pkg::RAD_SHIFT{1'b0}}};
    assign pair  = rfull[FULL_W-1-2*j -: 2];
    assign trial = {s_rem_r[j], pair};
    assign sub   = {2'b00, s_root_r[j], 2'b01};
    assign ge    = (trial >= sub);
    assign diff  = trial - sub;

    always_ff @(posedge clk) begin
      if (en) begin
        s_root_r[j+1] <= {s_root_r[j][ROOT_W-2:0], ge};
        s_den_r[j+1]  <= s_den_r[j];
        s_neg_r[j+1]  <= s_neg_r[j];
        s_zero_r[j+1] <= s_zero_r[j];
      end
    end

    if (j < SQRT_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          s_rad_r[j+1] <= s_rad_r[j];
          s_rem_r[j+1] <= ge ? diff[SREM_W-1:0] : trial[SREM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_num_r[0]  <= NUM_W'(s_root_r[SQRT_STEPS]) * NUM_W'(rdic_pkg::GEO_CELL);
      d_den_r[0]  <= s_den_r[SQRT_STEPS];
      d_neg_r[0]  <= s_neg_r[SQRT_STEPS];
      d_zero_r[0] <= s_zero_r[SQRT_STEPS];
      d_rem_r[0]  <= '0;
      d_quo_r[0]  <= '0;
    end
  end

  // Restoring division; the numerator's low bits below the root product are zero.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic              nbit;
    logic [DREM_W:0]   trial;
    logic [DREM_W:0]   diff;
    logic              ge;

    if (j < NUM_W) begin : g_nbit
      assign nbit = d_num_r[j][NUM_W-1-j];
    end else begin : g_zbit
      assign nbit = 1'b0;
    end

    assign trial = {d_rem_r[j], nbit};
    assign ge    = (trial >= {1'b0, d_den_r[j]});
    assign diff  = trial - {1'b0, d_den_r[j]};

    always_ff @(posedge clk) begin
      if (en) begin
        d_quo_r[j+1]  <= {d_quo_r[j][QUO_W-2:0], ge};
        d_neg_r[j+1]  <= d_neg_r[j];
        d_zero_r[j+1] <= d_zero_r[j];
      end
    end

    if (j < DIV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          d_den_r[j+1] <= d_den_r[j];
          d_rem_r[j+1] <= ge ? diff[DREM_W-1:0] : trial[DREM_W-1:0];
        end
      end
    end

    if (j < NUM_W - 1) begin : g_num
      always_ff @(posedge clk) begin
        if (en) begin
          d_num_r[j+1] <= d_num_r[j];
        end
      end
    end
  end

  assign quo_ext = COEF_W'(d_quo_r[DIV_STEPS]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (d_zero_r[DIV_STEPS]) begin
        g_r <= '0;
      end else if (d_neg_r[DIV_STEPS]) begin
        g_r <= signed'(-quo_ext);
      end else begin
        g_r <= signed'(quo_ext);
      end
    end
  end

  assign g = g_r;

endmodule

`default_nettype wire

@@ rtl/rect_dislocation_influence_coeff.sv @@
// ----------------------------------------------------------------------------
// Rectangular dislocation influence coefficient
// One influence matrix entry per transaction: row, column and coefficient.
// ----------------------------------------------------------------------------
// Usage: an input transaction carries a receiver cell and a source cell; the
// result transaction carries the matrix row and column, the coefficient in
// signed Q23.40 and an index error flag. Both channels use valid and stall.
// The user must write cell counts and origin offsets via the configuration
// port only while idle; the block itself does not enforce this. Each of the
// eight kernel units holds 32 square root and 63 divider steps. All stages
// run in lock step, one transaction per cycle unless the output stalls.
// When the output register holds a result and out_stall is high, the whole
// pipeline holds and in_stall is raised; nothing is lost or repeated.
// Reset clears the valid bits and loads the register defaults: 64 cells
// along x and y, x origin 0, y origin 32.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_dislocation_influence_coeff (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rdic_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rdic_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rdic_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rdic_pkg::out_item_t             out_data
);

  localparam int CFG_W  = rdic_pkg::CFG_W;
  localparam int GEO_W  = rdic_pkg::GEO_W;
  localparam int POS_W  = rdic_pkg::POS_W;
  localparam int COEF_W = rdic_pkg::COEF_W;
  localparam int N_TERMS = rdic_pkg::N_TERMS;
  localparam int KLAT   = rdic_pkg::KERNEL_LAT;
  localparam int PIPE_N = KLAT + 6;
  localparam int IDX_P  = KLAT + 5;
  localparam int HALF_W = COEF_W / 2;
  localparam int PROD_W = HALF_W + rdic_pkg::SCALE_W;

  logic [CFG_W-1:0] x_count_r;
  logic [CFG_W-1:0] y_count_r;
  logic [CFG_W-1:0] x_origin_r;
  logic [CFG_W-1:0] y_origin_r;

  logic en;
  logic [PIPE_N-1:0] vld_r;
  rdic_pkg::meta_t   meta_r [0:PIPE_N-1];
  rdic_pkg::meta_t   meta_in;

  logic [CFG_W-1:0] nx;
  logic [CFG_W-1:0] ny;
  logic             idx_err;
  logic [POS_W:0]   row_full;
  logic [POS_W:0]   col_full;

  logic signed [GEO_W-1:0] kx_s, ky_s, sx_s, sy_s, xo_s, yo_s;
  logic signed [GEO_W-1:0] x1_nxt, x2_nxt, a_nxt, b_nxt, c_nxt;
  logic signed [GEO_W-1:0] x1_r, x2_r, a_r, b_r, c_r, d_r;

  logic signed [GEO_W-1:0]  ku [N_TERMS];
  logic signed [GEO_W-1:0]  kv [N_TERMS];
  logic signed [COEF_W-1:0] kg [N_TERMS];
  logic signed [COEF_W-1:0] term [N_TERMS];

  logic signed [COEF_W-1:0] p_r [4];
  logic signed [COEF_W-1:0] q_r [2];
  logic signed [COEF_W-1:0] sum_r;
  logic [COEF_W-1:0]        mag_r;
  logic                     pos_r;
  logic [COEF_W-1:0]        mag_nxt;
  logic [PROD_W-1:0]        hi_prod_r;
  logic [PROD_W-1:0]        lo_prod;
  logic [rdic_pkg::SCALE_W-1:0] lo_part_r;
  logic                     pos_p_r;
  logic [COEF_W-1:0]        scaled;
  logic [COEF_W-1:0]        clamped;

  logic                out_valid_r;
  rdic_pkg::out_item_t out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_count_r  <= 7'd64;
      y_count_r  <= 7'd64;
      x_origin_r <= 7'd0;
      y_origin_r <= 7'd32;
    end else if (cfg_we) begin
      unique case (rdic_pkg::cfg_reg_t'(cfg_index))
        rdic_pkg::REG_X_COUNT:  x_count_r  <= cfg_data;
        rdic_pkg::REG_Y_COUNT:  y_count_r  <= cfg_data;
        rdic_pkg::REG_X_ORIGIN: x_origin_r <= cfg_data;
        rdic_pkg::REG_Y_ORIGIN: y_origin_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the output register can take a result.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign nx = (x_count_r > CFG_W'(rdic_pkg::MAX_X_CELLS)) ?
              CFG_W'(rdic_pkg::MAX_X_CELLS) : x_count_r;
  assign ny = (y_count_r > CFG_W'(rdic_pkg::MAX_Y_CELLS)) ?
              CFG_W'(rdic_pkg::MAX_Y_CELLS) : y_count_r;

  assign idx_err = (CFG_W'(in_data.recv_x) >= nx) || (CFG_W'(in_data.src_x) >= nx) ||
                   (CFG_W'(in_data.recv_y) >= ny) || (CFG_W'(in_data.src_y) >= ny);

  assign row_full = (POS_W+1)'(in_data.recv_x) * (POS_W+1)'(ny) +
                    (POS_W+1)'(in_data.recv_y);
  assign col_full = (POS_W+1)'(in_data.src_x) * (POS_W+1)'(ny) +
                    (POS_W+1)'(in_data.src_y);

  always_comb begin
    meta_in.row_index   = row_full[POS_W-1:0];
    meta_in.col_index   = col_full[POS_W-1:0];
    meta_in.index_error = idx_err;
    meta_in.src_on_axis = (in_data.src_x == '0);
  end

  // Geometry in hundredths of a cell.
  assign kx_s = signed'(GEO_W'(in_data.recv_x));
  assign ky_s = signed'(GEO_W'(in_data.recv_y));
  assign sx_s = signed'(GEO_W'(in_data.src_x));
  assign sy_s = signed'(GEO_W'(in_data.src_y));
  assign xo_s = signed'(GEO_W'(x_origin_r));
  assign yo_s = signed'(GEO_W'(y_origin_r));

  assign x1_nxt = (in_data.recv_x == '0) ? rdic_pkg::GEO_NEAR :
                  (kx_s - xo_s) * rdic_pkg::GEO_CELL;
  assign x2_nxt = (ky_s + 16'sd1 - yo_s) * rdic_pkg::GEO_CELL;
  assign a_nxt  = (in_data.src_x == '0) ? '0 :
                  (sx_s - xo_s) * rdic_pkg::GEO_CELL - rdic_pkg::GEO_HALF;
  assign b_nxt  = (sx_s + 16'sd1 - xo_s) * rdic_pkg::GEO_CELL - rdic_pkg::GEO_HALF;
  assign c_nxt  = (sy_s - yo_s) * rdic_pkg::GEO_CELL + rdic_pkg::GEO_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= x1_nxt;
      x2_r <= x2_nxt;
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      c_r  <= c_nxt;
      d_r  <= c_nxt + rdic_pkg::GEO_CELL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_r[0] <= meta_in;
      for (int i = 1; i < PIPE_N; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
    end
  end

  // Rectangle term and its mirror image about x = 0.
  always_comb begin
    ku[0] = x1_r - b_r;  kv[0] = x2_r - c_r;
    ku[1] = x1_r - b_r;  kv[1] = x2_r - d_r;
    ku[2] = x1_r + b_r;  kv[2] = c_r - x2_r;
    ku[3] = x1_r + b_r;  kv[3] = d_r - x2_r;
    ku[4] = x1_r - a_r;  kv[4] = x2_r - c_r;
    ku[5] = x1_r - a_r;  kv[5] = x2_r - d_r;
    ku[6] = x1_r + a_r;  kv[6] = c_r - x2_r;
    ku[7] = x1_r + a_r;  kv[7] = d_r - x2_r;
  end

  for (genvar i = 0; i < N_TERMS; i++) begin : g_kernel
    rdic_kernel u_kernel (
      .clk (clk),
      .en  (en),
      .u   (ku[i]),
      .v   (kv[i]),
      .g   (kg[i])
    );
  end

  // With the source on the symmetry line the lower-edge terms cancel exactly.
  always_comb begin
    for (int i = 0; i < N_TERMS; i++) begin
      if (rdic_pkg::TERM_LOWER[i] && meta_r[KLAT].src_on_axis) begin
        term[i] = '0;
      end else if (rdic_pkg::TERM_NEG[i]) begin
        term[i] = -kg[i];
      end else begin
        term[i] = kg[i];
      end
    end
  end

  assign mag_nxt = sum_r[COEF_W-1] ? COEF_W'(-sum_r) : COEF_W'(sum_r);
  assign lo_prod = PROD_W'(mag_r[HALF_W-1:0]) * PROD_W'(rdic_pkg::SCALE_K);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        p_r[k] <= term[2*k] + term[2*k+1];
      end
      q_r[0]    <= p_r[0] + p_r[1];
      q_r[1]    <= p_r[2] + p_r[3];
      sum_r     <= q_r[0] + q_r[1];
      mag_r     <= mag_nxt;
      pos_r     <= !sum_r[COEF_W-1];
      hi_prod_r <= PROD_W'(mag_r[COEF_W-1:HALF_W]) * PROD_W'(rdic_pkg::SCALE_K);
      lo_part_r <= lo_prod[PROD_W-1:HALF_W];
      pos_p_r   <= pos_r;
    end
  end

  assign scaled  = COEF_W'(hi_prod_r) + COEF_W'(lo_part_r);
  assign clamped = scaled[COEF_W-1] ? {1'b0, {(COEF_W-1){1'b1}}} : scaled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[PIPE_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (meta_r[IDX_P].index_error) begin
        out_data_r.row_index   <= '0;
        out_data_r.col_index   <= '0;
        out_data_r.coefficient <= '0;
        out_data_r.index_error <= 1'b1;
      end else begin
        out_data_r.row_index   <= meta_r[IDX_P].row_index;
        out_data_r.col_index   <= meta_r[IDX_P].col_index;
        out_data_r.coefficient <= pos_p_r ? signed'(-clamped) : signed'(clamped);
        out_data_r.index_error <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/rdic_checker.sv @@
// ----------------------------------------------------------------------------
// Rectangular dislocation influence coefficient: port checker
// Concurrent assertions on the top level's ports, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rdic_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input rdic_pkg::out_item_t out_data
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  // A stalled result keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // A full, stalled output register holds the whole pipeline.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while the output is stalled");

  // An index error carries no matrix position and no coefficient.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_error |->
      (out_data.coefficient == '0) && (out_data.row_index == '0) &&
      (out_data.col_index == '0))
    else $error("index error with a nonzero payload");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind rect_dislocation_influence_coeff rdic_checker u_rdic_checker (.*);

`default_nettype wire

@@ sim/rect_dislocation_influence_coeff_tb.sv @@
// ----------------------------------------------------------------------------
// Rectangular dislocation influence coefficient: testbench
// Drives receiver/source cell pairs through the valid/stall channel under
// random gaps and stalls, predicts row, column, coefficient and index error
// in the bench itself, and compares every result transaction in order.
// ----------------------------------------------------------------------------
module rect_dislocation_influence_coeff_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 106;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 850;
  localparam longint unsigned K_SCALE = 64'd170891319;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [rdic_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rdic_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  rdic_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rdic_pkg::out_item_t out_data;

  always #2 clk = ~clk;

  rect_dislocation_influence_coeff i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  // Bench copy of the register file.
  logic [rdic_pkg::CFG_W-1:0] nx_cells, ny_cells, x_org, y_org;

  rdic_pkg::out_item_t pending_entries[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= r + bit_v) begin
        n -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return r;
  endfunction

  function automatic longint rect_kernel(longint u, longint v);
    longint unsigned au, av, s, mag;
    au = (u < 0) ? -u : u;
    av = (v < 0) ? -v : v;
    if (au == 0 || av == 0) return 0;
    s = int_sqrt((au * au + av * av) << 32);
    mag = ((s * 100) << 24) / (au * av);
    return ((u < 0) != (v < 0)) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic rdic_pkg::out_item_t influence_entry(rdic_pkg::in_item_t it);
    rdic_pkg::out_item_t r;
    longint unsigned nx, ny, kx, ky, sx, sy, mag, m;
    longint xo, yo, x1, x2, a, b, c, d, sum;
    nx = (nx_cells > rdic_pkg::MAX_X_CELLS) ? rdic_pkg::MAX_X_CELLS : nx_cells;
    ny = (ny_cells > rdic_pkg::MAX_Y_CELLS) ? rdic_pkg::MAX_Y_CELLS : ny_cells;
    kx = it.recv_x; ky = it.recv_y; sx = it.src_x; sy = it.src_y;
    r = '0;
    if (kx >= nx || sx >= nx || ky >= ny || sy >= ny) begin
      r.index_error = 1'b1;
      return r;
    end
    xo = x_org; yo = y_org;
    x1 = (kx == 0) ? 1 : (longint'(kx) - xo) * 100;
    x2 = (longint'(ky) + 1 - yo) * 100;
    a = (sx == 0) ? 0 : (longint'(sx) - xo) * 100 - 50;
    b = (longint'(sx) + 1 - xo) * 100 - 50;
    c = (longint'(sy) - yo) * 100 + 50;
    d = c + 100;
    sum = rect_kernel(x1 - b, x2 - c) - rect_kernel(x1 - b, x2 - d)
        + rect_kernel(x1 + b, c - x2) - rect_kernel(x1 + b, d - x2);
    if (sx != 0)
      sum += -rect_kernel(x1 - a, x2 - c) + rect_kernel(x1 - a, x2 - d)
           - rect_kernel(x1 + a, c - x2) + rect_kernel(x1 + a, d - x2);
    mag = (sum < 0) ? -sum : sum;
    m = (mag >> 32) * K_SCALE + (((mag & 64'hFFFF_FFFF) * K_SCALE) >> 32);
    if (m > 64'h7FFF_FFFF_FFFF_FFFF) m = 64'h7FFF_FFFF_FFFF_FFFF;
    r.coefficient = (sum >= 0) ? -longint'(m) : longint'(m);
    r.row_index = rdic_pkg::POS_W'(kx * ny + ky);
    r.col_index = rdic_pkg::POS_W'(sx * ny + sy);
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic write_reg(rdic_pkg::cfg_reg_t idx, logic [rdic_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rdic_pkg::REG_X_COUNT:  nx_cells = val;
      rdic_pkg::REG_Y_COUNT:  ny_cells = val;
      rdic_pkg::REG_X_ORIGIN: x_org = val;
      default:                y_org = val;
    endcase
  endtask

  task automatic set_mesh(logic [rdic_pkg::CFG_W-1:0] nx, logic [rdic_pkg::CFG_W-1:0] ny,
                          logic [rdic_pkg::CFG_W-1:0] xo, logic [rdic_pkg::CFG_W-1:0] yo);
    write_reg(rdic_pkg::REG_X_COUNT, nx);
    write_reg(rdic_pkg::REG_Y_COUNT, ny);
    write_reg(rdic_pkg::REG_X_ORIGIN, xo);
    write_reg(rdic_pkg::REG_Y_ORIGIN, yo);
  endtask

  // Offers one transaction from a falling edge and holds it until accepted.
  task automatic send_cells(rdic_pkg::in_item_t it, bit has_exp,
                            rdic_pkg::out_item_t exp_r);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_entries.insert(pending_entries.size(),
                           has_exp ? exp_r : influence_entry(it));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic send_batch(int n, int hi_idx);
    rdic_pkg::in_item_t it;
    int g;
    for (int i = 0; i < n; i++) begin
      it.recv_x = rdic_pkg::IDX_W'($urandom_range(0, hi_idx));
      it.recv_y = rdic_pkg::IDX_W'($urandom_range(0, hi_idx));
      it.src_x = rdic_pkg::IDX_W'($urandom_range(0, hi_idx));
      it.src_y = rdic_pkg::IDX_W'($urandom_range(0, hi_idx));
      if ($urandom_range(0, 7) == 0) it = $bits(rdic_pkg::in_item_t)'($urandom);
      send_cells(it, 1'b0, '0);
      g = gap_len();
      if (g != 0) begin
        in_valid <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  endtask

  typedef struct {
    rdic_pkg::in_item_t cells;
    bit has_exp;
    rdic_pkg::out_item_t exp_r;
  } stim_row_t;

  stim_row_t directed[$];

  task automatic add_row(rdic_pkg::in_item_t cells, bit has_exp,
                         rdic_pkg::out_item_t exp_r);
    stim_row_t row;
    row.cells = cells;
    row.has_exp = has_exp;
    row.exp_r = exp_r;
    directed.insert(directed.size(), row);
  endtask

  // Receiver side: random stalls plus one long hold while the sender presses on.
  initial begin
    int g;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else begin
        g = gap_len();
        if (g != 0) begin
          out_stall <= 1'b1;
          repeat (g) @(negedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    rdic_pkg::out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = pending_entries.pop_front();
        if (out_data.row_index !== e.row_index || out_data.col_index !== e.col_index ||
            out_data.coefficient !== e.coefficient ||
            out_data.index_error !== e.index_error) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, out_data);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rdic_pkg::out_item_t err_r;
    err_r = '0;
    err_r.index_error = 1'b1;
    nx_cells = 7'd64; ny_cells = 7'd64; x_org = 7'd0; y_org = 7'd32;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Defaults after reset, corners and the symmetry-line source.
    add_row('{6'd0, 6'd0, 6'd0, 6'd0}, 1'b0, '0);
    add_row('{6'd63, 6'd63, 6'd63, 6'd63}, 1'b0, '0);
    add_row('{6'd0, 6'd31, 6'd0, 6'd31}, 1'b0, '0);
    add_row('{6'd1, 6'd31, 6'd1, 6'd31}, 1'b0, '0);
    add_row('{6'd0, 6'd31, 6'd1, 6'd30}, 1'b0, '0);
    add_row('{6'd63, 6'd0, 6'd0, 6'd63}, 1'b0, '0);
    add_row('{6'd5, 6'd10, 6'd0, 6'd32}, 1'b0, '0);
    add_row('{6'd42, 6'd21, 6'd21, 6'd42}, 1'b0, '0);
    foreach (directed[i]) send_cells(directed[i].cells, directed[i].has_exp, directed[i].exp_r);
    drain();

    // Small mesh: every field out of range in turn.
    set_mesh(7'd8, 7'd4, 7'd0, 7'd2);
    directed.delete();
    add_row('{6'd8, 6'd0, 6'd0, 6'd0}, 1'b1, err_r);
    add_row('{6'd0, 6'd4, 6'd0, 6'd0}, 1'b1, err_r);
    add_row('{6'd0, 6'd0, 6'd8, 6'd0}, 1'b1, err_r);
    add_row('{6'd0, 6'd0, 6'd0, 6'd4}, 1'b1, err_r);
    add_row('{6'd7, 6'd3, 6'd7, 6'd3}, 1'b0, '0);
    add_row('{6'd63, 6'd63, 6'd63, 6'd63}, 1'b1, err_r);
    foreach (directed[i]) send_cells(directed[i].cells, directed[i].has_exp, directed[i].exp_r);
    drain();

    // Zero counts reject everything.
    set_mesh(7'd0, 7'd0, 7'd0, 7'd0);
    send_cells('{6'd0, 6'd0, 6'd0, 6'd0}, 1'b1, err_r);
    drain();

    // Register extremes: counts above the maximum clamp, origins at 64 and 127.
    set_mesh(7'd127, 7'd127, 7'd127, 7'd127);
    send_batch(40, 63);
    drain();
    set_mesh(7'd1, 7'd1, 7'd64, 7'd64);
    send_batch(15, 1);
    drain();

    // Default geometry with a long receiver hold so the pipeline backs up.
    set_mesh(7'd64, 7'd64, 7'd0, 7'd32);
    long_hold = 1'b1;
    send_batch(300, 63);
    drain();
    set_mesh(7'd16, 7'd48, 7'd5, 7'd20);
    send_batch(250, 63);
    drain();
    set_mesh(7'd64, 7'd33, 7'd40, 7'd0);
    send_batch(N_RANDOM - 605, 63);
    drain();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
